[hw/rtl/prnbf_pkg.sv]
// Shared types and constants for the page run allocator.
// No dependencies; compiled first.
package prnbf_pkg;

  localparam int HEAP_PAGES = 4096;
  localparam int PAGE_W     = 12;          // page index bits
  localparam int CNT_W      = 13;          // page count, 0..HEAP_PAGES
  localparam int ADDR_W     = 32;
  localparam int OFFS_W     = 12;          // byte offset inside a page
  localparam int SPAN_W     = PAGE_W + OFFS_W;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(HEAP_PAGES - 1);
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'hF600_0000;

  // configuration register indexes
  localparam logic CFG_STRATEGY  = 1'b0;
  localparam logic CFG_HEAP_BASE = 1'b1;

  // placement strategy values
  localparam logic STRAT_NEXT = 1'b0;
  localparam logic STRAT_BEST = 1'b1;

  // request mode values
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [2:0] {
    RES_ALLOC   = 3'd0,
    RES_NOSPACE = 3'd1,
    RES_FREED   = 3'd2,
    RES_IGNORED = 3'd3,
    RES_RANGE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MARK_INIT,
    ST_MARK,
    ST_FREE_CHK,
    ST_FREE_CLR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic    clr;        // clearing pass step
    logic    load;       // capture request transaction
    logic    scan_init;
    logic    scan;
    logic    mark_init;
    logic    mark;
    logic    finit;
    logic    fclr;
    logic    fin;        // load output register
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic req_ok;
    logic in_range;
    logic scan_done;
    logic scan_found;
    logic mark_last;
    logic len_zero;
    logic fclr_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/prnbf_if.sv]
// Request and response channel interfaces.
// Depends on prnbf_pkg.
interface prnbf_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [prnbf_pkg::ADDR_W-1:0]  request_bytes;
  logic [prnbf_pkg::ADDR_W-1:0]  free_address;

  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink   (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface prnbf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [prnbf_pkg::ADDR_W-1:0]  block_address;
  logic [prnbf_pkg::CNT_W-1:0]   page_count;

  modport source (output valid, status, block_address, page_count, input ready);
  modport sink   (input valid, status, block_address, page_count, output ready);
endinterface

[hw/rtl/prnbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prnbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/prnbf_ctrl.sv]
// Sequencer for the page run allocator.
// Depends on prnbf_pkg; drives prnbf_dp through cmd_t / sts_t.
module prnbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  prnbf_pkg::sts_t  sts,
  output prnbf_pkg::cmd_t  cmd
);
  import prnbf_pkg::*;

  state_t  state, state_next;
  status_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      code  <= RES_NOSPACE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.code   = code;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_free) begin
          if (!sts.in_range) begin
            code_next  = RES_RANGE;
            state_next = ST_RESP;
          end else begin
            state_next = ST_FREE_CHK;
          end
        end else if (!sts.req_ok) begin
          code_next  = RES_NOSPACE;
          state_next = ST_RESP;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.scan_found) begin
            state_next = ST_MARK_INIT;
          end else begin
            code_next  = RES_NOSPACE;
            state_next = ST_RESP;
          end
        end
      end
      ST_MARK_INIT: begin
        cmd.mark_init = 1'b1;
        state_next    = ST_MARK;
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          code_next  = RES_ALLOC;
          state_next = ST_RESP;
        end
      end
      ST_FREE_CHK: begin
        if (sts.len_zero) begin
          code_next  = RES_IGNORED;
          state_next = ST_RESP;
        end else begin
          cmd.finit  = 1'b1;
          state_next = ST_FREE_CLR;
        end
      end
      ST_FREE_CLR: begin
        cmd.fclr = 1'b1;
        if (sts.fclr_last) begin
          code_next  = RES_FREED;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end
endmodule

[hw/rtl/prnbf_dp.sv]
// Datapath: occupancy and run-length memories, scan pipeline, result register.
// Depends on prnbf_pkg and prnbf_ram.
module prnbf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  prnbf_pkg::cmd_t               cmd,
  output prnbf_pkg::sts_t               sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [prnbf_pkg::ADDR_W-1:0]  cfg_wdata,
  input  logic                          mode,
  input  logic [prnbf_pkg::ADDR_W-1:0]  request_bytes,
  input  logic [prnbf_pkg::ADDR_W-1:0]  free_address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [2:0]                    status,
  output logic [prnbf_pkg::ADDR_W-1:0]  block_address,
  output logic [prnbf_pkg::CNT_W-1:0]   page_count
);
  import prnbf_pkg::*;

  // configuration
  logic              strat;
  logic [ADDR_W-1:0] base;

  // captured request
  logic              mode_r;
  logic [CNT_W-1:0]  need;
  logic              req_ok;
  logic [ADDR_W-1:0] faddr;

  logic [CNT_W-1:0]  cur;        // next-fit cursor, 0..HEAP_PAGES
  logic [PAGE_W-1:0] ptr;        // shared page pointer
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  flen;
  logic [PAGE_W-1:0] start_r;

  // scan issue side
  logic iss_en, pass, fresh, sent;
  // scan check side
  logic              chk_vld, chk_fresh, chk_sent, chk_last;
  logic [PAGE_W-1:0] chk_pg;
  logic [CNT_W-1:0]  run;
  logic [PAGE_W-1:0] hole;
  logic              bfound;
  logic [CNT_W-1:0]  best_len;
  logic [PAGE_W-1:0] best_pg;

  // memories
  logic              used_we, used_wdata, used_rdata;
  logic              len_we;
  logic [PAGE_W-1:0] len_waddr;
  logic [CNT_W-1:0]  len_wdata, len_rdata;

  // address decode for free
  logic [ADDR_W-1:0] diff;
  logic [PAGE_W-1:0] idx;
  logic [PAGE_W+8:0] pages;

  assign diff  = faddr - base;
  assign idx   = diff[SPAN_W-1:OFFS_W];
  assign pages = PAGE_W'(0) + 21'(({1'b0, request_bytes} + 33'd4095) >> OFFS_W);

  prnbf_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES)) u_used (
    .clk(clk), .we(used_we), .waddr(ptr), .wdata(used_wdata),
    .raddr(ptr), .rdata(used_rdata)
  );

  prnbf_ram #(.WIDTH(CNT_W), .DEPTH(HEAP_PAGES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(idx), .rdata(len_rdata)
  );

  assign used_we    = cmd.clr | cmd.mark | cmd.fclr;
  assign used_wdata = cmd.mark;
  assign len_we     = cmd.clr | cmd.mark_init | cmd.finit;
  assign len_waddr  = cmd.clr ? ptr : (cmd.mark_init ? start_r : idx);
  assign len_wdata  = cmd.mark_init ? need : '0;

  // scan issue: next pointer and end of issue
  logic              iss_last;
  logic [PAGE_W-1:0] ptr_adv;
  logic              pass_adv, fresh_adv, sent_adv;
  logic [CNT_W-1:0]  cur_m1;

  assign cur_m1 = cur - CNT_W'(1);

  always_comb begin
    ptr_adv   = ptr + PAGE_W'(1);
    pass_adv  = pass;
    fresh_adv = 1'b0;
    sent_adv  = sent;
    iss_last  = 1'b0;
    if (strat == STRAT_BEST) begin
      iss_last = sent;
      if (ptr == LAST_PAGE) sent_adv = 1'b1;
    end else if (!pass) begin
      if (ptr == LAST_PAGE) begin
        if (cur == '0) begin
          iss_last = 1'b1;
        end else begin
          ptr_adv   = '0;
          pass_adv  = 1'b1;
          fresh_adv = 1'b1;
        end
      end
    end else begin
      iss_last = ({1'b0, ptr} == cur_m1);
    end
  end

  // scan check: next-fit
  logic              used_c;
  logic [CNT_W-1:0]  nf_run;
  logic              nf_hit;
  logic [PAGE_W-1:0] nf_start;

  assign used_c   = used_rdata | chk_sent;
  assign nf_run   = used_c ? '0 : ((chk_fresh ? '0 : run) + CNT_W'(1));
  assign nf_hit   = (nf_run >= need);
  assign nf_start = PAGE_W'({1'b0, chk_pg} + CNT_W'(1) - need);

  // scan check: best-fit
  logic [CNT_W-1:0]  bf_run;
  logic [PAGE_W-1:0] bf_hole;
  logic              bf_found, bf_fits;
  logic [CNT_W-1:0]  bf_len;
  logic [PAGE_W-1:0] bf_start;

  always_comb begin
    bf_run   = '0;
    bf_hole  = hole;
    bf_found = bfound;
    bf_len   = best_len;
    bf_start = best_pg;
    bf_fits  = (run >= need) && (!bfound || run < best_len);
    if (!used_c) begin
      bf_run = run + CNT_W'(1);
      if (run == '0) bf_hole = chk_pg;
    end else if (bf_fits) begin
      bf_found = 1'b1;
      bf_len   = run;
      bf_start = hole;
    end
  end

  logic scan_done, scan_found;
  assign scan_done  = chk_vld && ((strat == STRAT_NEXT) ? (nf_hit || chk_last) : chk_last);
  assign scan_found = (strat == STRAT_NEXT) ? nf_hit : bf_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      strat     <= STRAT_NEXT;
      base      <= BASE_RESET;
      cur       <= '0;
      ptr       <= '0;
      iss_en    <= 1'b0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STRATEGY) strat <= cfg_wdata[0];
        else                           base  <= cfg_wdata;
      end

      if (cmd.clr) ptr <= ptr + PAGE_W'(1);

      if (cmd.scan_init) begin
        ptr     <= (strat == STRAT_BEST || cur[PAGE_W]) ? '0 : cur[PAGE_W-1:0];
        pass    <= (strat == STRAT_NEXT) && cur[PAGE_W];
        fresh   <= 1'b0;
        sent    <= 1'b0;
        iss_en  <= 1'b1;
        chk_vld <= 1'b0;
        run     <= '0;
        hole    <= '0;
        bfound  <= 1'b0;
      end

      if (cmd.scan) begin
        chk_vld   <= iss_en;
        chk_pg    <= ptr;
        chk_fresh <= fresh;
        chk_sent  <= sent;
        chk_last  <= iss_last;
        if (iss_en) begin
          ptr    <= ptr_adv;
          pass   <= pass_adv;
          fresh  <= fresh_adv;
          sent   <= sent_adv;
          iss_en <= !iss_last;
        end
        if (chk_vld) begin
          if (strat == STRAT_NEXT) begin
            run <= nf_run;
          end else begin
            run      <= bf_run;
            hole     <= bf_hole;
            bfound   <= bf_found;
            best_len <= bf_len;
            best_pg  <= bf_start;
          end
        end
        if (scan_done && scan_found)
          start_r <= (strat == STRAT_NEXT) ? nf_start : bf_start;
      end

      if (cmd.mark_init) begin
        ptr <= start_r;
        cnt <= need;
        if (strat == STRAT_NEXT) cur <= {1'b0, start_r} + need;
      end
      if (cmd.mark) begin
        ptr <= ptr + PAGE_W'(1);
        cnt <= cnt - CNT_W'(1);
      end

      if (cmd.finit) begin
        ptr  <= idx;
        cnt  <= len_rdata;
        flen <= len_rdata;
      end
      if (cmd.fclr) begin
        ptr <= ptr + PAGE_W'(1);
        cnt <= cnt - CNT_W'(1);
      end

      if (cmd.fin)            rsp_valid <= 1'b1;
      else if (rsp_ready)     rsp_valid <= 1'b0;
    end
  end

  // request capture and result register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      need   <= pages[CNT_W-1:0];
      req_ok <= (pages != '0) && (pages <= (PAGE_W+9)'(HEAP_PAGES));
      faddr  <= free_address;
    end
    if (cmd.fin) begin
      status        <= cmd.code;
      block_address <= (cmd.code == RES_ALLOC) ?
                       base + {8'd0, start_r, 12'd0} : '0;
      page_count    <= (cmd.code == RES_ALLOC) ? need :
                       (cmd.code == RES_FREED) ? flen : '0;
    end
  end

  always_comb begin
    sts.clr_last   = (ptr == LAST_PAGE);
    sts.is_free    = (mode_r == MODE_FREE);
    sts.req_ok     = req_ok;
    sts.in_range   = (faddr >= base) && (diff[ADDR_W-1:SPAN_W] == '0);
    sts.scan_done  = scan_done;
    sts.scan_found = scan_found;
    sts.mark_last  = (cnt == CNT_W'(1));
    sts.len_zero   = (len_rdata == '0);
    sts.fclr_last  = (cnt == CNT_W'(1)) || (ptr == LAST_PAGE);
    sts.out_free   = !rsp_valid || rsp_ready;
  end
endmodule

[hw/rtl/page_run_allocator_next_best_fit.sv]
// Top level of the page run allocator: sequencer plus datapath.
// Depends on prnbf_pkg, prnbf_if, prnbf_ram, prnbf_ctrl, prnbf_dp.
//
// Usage
//   req channel (valid/ready): mode 0 allocates request_bytes rounded up to
//   4 KiB pages, mode 1 frees the block at free_address.
//   rsp channel (valid/ready): one transaction per request carrying status,
//   block_address and page_count.
//   cfg port: cfg_we/cfg_index/cfg_wdata; index 0 selects next-fit (0) or
//   best-fit (1), index 1 sets heap_base. Write only while idle.
// Timing
//   One request is handled at a time. Allocation scans the occupancy memory
//   one page per cycle through its single read port: next-fit stops at the
//   first run that fits (up to 4096 pages checked), best-fit always checks
//   all 4096 pages plus the heap end. Marking then sets the run's pages.
//   Allocation steps: decode, scan, mark setup, marking, response (scan to
//   response if nothing fits). Free steps: decode, length check, clearing,
//   response; zero size, oversize or out of heap go from decode to response,
//   a free without a record from the length check.
// Reset
//   After rst the block sweeps every page of both memories clean, with
//   req.ready low; config writes are still taken.
// Backpressure
//   The result sits in an output register; a new request is taken while it
//   waits, and the next result is held back until rsp.ready frees the slot.
module page_run_allocator_next_best_fit (
  input  logic                          clk,
  input  logic                          rst,
  prnbf_req_if.sink                     req,
  prnbf_rsp_if.source                   rsp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [prnbf_pkg::ADDR_W-1:0]  cfg_wdata
);
  import prnbf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the handshake on the request side
  prnbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: memories, scan, config and the output register
  prnbf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mode          (req.mode),
    .request_bytes (req.request_bytes),
    .free_address  (req.free_address),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .block_address (rsp.block_address),
    .page_count    (rsp.page_count)
  );
endmodule

[hw/rtl/prnbf_chk.sv]
// Port-level checker for the page run allocator, bound to the top level.
// Depends on prnbf_pkg.
module prnbf_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [2:0]                    status,
  input logic [prnbf_pkg::ADDR_W-1:0]  block_address,
  input logic [prnbf_pkg::CNT_W-1:0]   page_count
);
  import prnbf_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= RES_RANGE)
    else $error("status code out of range");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != RES_ALLOC |-> block_address == '0)
    else $error("address on a non-allocation result");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == RES_NOSPACE || status == RES_IGNORED || status == RES_RANGE)
      |-> page_count == '0)
    else $error("page count on a failed transaction");

  a_count_set: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == RES_ALLOC || status == RES_FREED)
      |-> page_count != '0 && page_count <= CNT_W'(HEAP_PAGES))
    else $error("bad page count on a successful transaction");
endmodule

bind page_run_allocator_next_best_fit prnbf_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .block_address (rsp.block_address),
  .page_count    (rsp.page_count)
);
